// ===== hdl/hpq_pkg.sv =====
// Package for the heap priority queue: sizes, entry layout, codes and
// the command and result item types. No dependencies.
`timescale 1ns / 1ps

package hpq_pkg;

  localparam int CAPACITY = 8192;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int POS_W    = $clog2(CAPACITY + 1);
  localparam int HANDLE_W = 13;
  localparam int PRI_W    = 10;
  localparam int COUNT_W  = 14;

  typedef enum logic [0:0] {
    ACT_INSERT = 1'b0,
    ACT_REMOVE = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [PRI_W-1:0]    pri;
  } entry_t;

  typedef struct packed {
    action_t             action;
    logic [HANDLE_W-1:0] handle;
    logic [PRI_W-1:0]    priority_req;
  } cmd_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] out_handle;
    logic [PRI_W-1:0]    out_priority;
    status_t             status;
    logic [COUNT_W-1:0]  entry_count;
  } rsp_t;

endpackage

// ===== hdl/max_priority_heap_queue_unit.sv =====
// Binary max-heap priority queue over one synchronous entry memory.
// Depends on hpq_pkg.
`timescale 1ns / 1ps

//  channel   | handshake        | payload
//  ----------+------------------+------------------------------
//  command   | start / busy     | action, handle, priority_req
//  result    | done (strobe)    | out_handle, out_priority, status, entry_count
//
// An insert into an empty or full heap, or a remove on an empty heap, is answered from idle;
// others walk the heap level by level, up for an insert and down for a remove.
// At each heap level the memory read is issued, the data compared and an entry written.
// The result strobe follows the last cycle; busy is low again in that same cycle.
// Reset clears the state, the entry count and done; the entry memory needs no clearing.
// The receiver cannot stall: done is high for exactly one cycle per item.

module max_priority_heap_queue_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  hpq_pkg::cmd_t command,
  output logic          done,
  output hpq_pkg::rsp_t result
);

  import hpq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RM_LOAD,
    S_UP_CMP,
    S_DN_CMP,
    S_PLACE
  } state_t;

  typedef logic [POS_W-1:0] pos_t;

  state_t            state, state_next;
  pos_t              idx, idx_next;
  pos_t              count, count_next;
  entry_t            carry, carry_next;
  entry_t            top, top_next;
  action_t           op, op_next;
  logic              done_next;
  rsp_t              result_next;

  entry_t            heap_mem [CAPACITY];
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  entry_t            wr_data;
  logic [ADDR_W-1:0] rd_a_addr, rd_b_addr;
  entry_t            rd_a_data, rd_b_data;

  // heap positions are 1-based
  function automatic logic [ADDR_W-1:0] slot_of(input pos_t p);
    pos_t k;
    k = p - pos_t'(1);
    return k[ADDR_W-1:0];
  endfunction

  function automatic rsp_t make_rsp(input action_t a, input entry_t e, input status_t s,
                                    input pos_t n);
    rsp_t r;
    r = '0;
    if (a == ACT_REMOVE && s == ST_OK) begin
      r.out_handle   = e.handle;
      r.out_priority = e.pri;
    end
    r.status      = s;
    r.entry_count = COUNT_W'(n);
    return r;
  endfunction

  // memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      heap_mem[wr_addr] <= wr_data;
    end
    rd_a_data <= heap_mem[rd_a_addr];
    rd_b_data <= heap_mem[rd_b_addr];
  end

  always_comb begin
    logic [POS_W:0] lpos;
    logic [POS_W:0] jpos2;
    pos_t           par;
    pos_t           jpos;
    entry_t         child;
    logic           use_right;

    state_next  = state;
    idx_next    = idx;
    count_next  = count;
    carry_next  = carry;
    top_next    = top;
    op_next     = op;
    done_next   = 1'b0;
    result_next = result;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = carry;
    rd_a_addr   = '0;
    rd_b_addr   = '0;
    lpos        = '0;
    jpos2       = '0;
    par         = '0;
    jpos        = '0;
    child       = rd_a_data;
    use_right   = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          op_next = command.action;
          if (command.action == ACT_INSERT) begin
            if (count == pos_t'(CAPACITY)) begin
              done_next   = 1'b1;
              result_next = make_rsp(ACT_INSERT, carry, ST_FULL, count);
            end else begin
              count_next = count + pos_t'(1);
              carry_next = '{handle: command.handle, pri: command.priority_req};
              idx_next   = count + pos_t'(1);
              if (count == '0) begin
                wr_en       = 1'b1;
                wr_addr     = '0;
                wr_data     = '{handle: command.handle, pri: command.priority_req};
                done_next   = 1'b1;
                result_next = make_rsp(ACT_INSERT, carry, ST_OK, count + pos_t'(1));
              end else begin
                rd_a_addr  = slot_of((count + pos_t'(1)) >> 1);
                state_next = S_UP_CMP;
              end
            end
          end else begin
            if (count == '0) begin
              done_next   = 1'b1;
              result_next = make_rsp(ACT_REMOVE, carry, ST_EMPTY, count);
            end else begin
              rd_a_addr  = '0;
              rd_b_addr  = slot_of(count);
              count_next = count - pos_t'(1);
              state_next = S_RM_LOAD;
            end
          end
        end
      end

      S_RM_LOAD: begin
        top_next   = rd_a_data;
        carry_next = rd_b_data;
        idx_next   = pos_t'(1);
        if (count == '0) begin
          done_next   = 1'b1;
          result_next = make_rsp(ACT_REMOVE, rd_a_data, ST_OK, count);
          state_next  = S_IDLE;
        end else if (count >= pos_t'(2)) begin
          rd_a_addr  = slot_of(pos_t'(2));
          rd_b_addr  = slot_of(pos_t'(3));
          state_next = S_DN_CMP;
        end else begin
          wr_en       = 1'b1;
          wr_addr     = '0;
          wr_data     = rd_b_data;
          done_next   = 1'b1;
          result_next = make_rsp(ACT_REMOVE, rd_a_data, ST_OK, count);
          state_next  = S_IDLE;
        end
      end

      S_UP_CMP: begin
        if (rd_a_data.pri < carry.pri) begin
          // move the parent down, climb one level
          wr_en    = 1'b1;
          wr_addr  = slot_of(idx);
          wr_data  = rd_a_data;
          par      = idx >> 1;
          idx_next = par;
          if (par > pos_t'(1)) begin
            rd_a_addr = slot_of(par >> 1);
          end else begin
            state_next = S_PLACE;
          end
        end else begin
          wr_en       = 1'b1;
          wr_addr     = slot_of(idx);
          wr_data     = carry;
          done_next   = 1'b1;
          result_next = make_rsp(ACT_INSERT, carry, ST_OK, count);
          state_next  = S_IDLE;
        end
      end

      S_DN_CMP: begin
        lpos      = {idx, 1'b0};
        use_right = (lpos < {1'b0, count}) && (rd_a_data.pri < rd_b_data.pri);
        child     = use_right ? rd_b_data : rd_a_data;
        jpos      = POS_W'(lpos) + (use_right ? pos_t'(1) : pos_t'(0));
        jpos2     = {jpos, 1'b0};
        if (child.pri <= carry.pri) begin
          wr_en       = 1'b1;
          wr_addr     = slot_of(idx);
          wr_data     = carry;
          done_next   = 1'b1;
          result_next = make_rsp(ACT_REMOVE, top, ST_OK, count);
          state_next  = S_IDLE;
        end else begin
          // lift the larger child, descend one level
          wr_en    = 1'b1;
          wr_addr  = slot_of(idx);
          wr_data  = child;
          idx_next = jpos;
          if (jpos2 <= {1'b0, count}) begin
            rd_a_addr = slot_of(POS_W'(jpos2));
            rd_b_addr = slot_of(POS_W'(jpos2) + pos_t'(1));
          end else begin
            state_next = S_PLACE;
          end
        end
      end

      S_PLACE: begin
        wr_en       = 1'b1;
        wr_addr     = slot_of(idx);
        wr_data     = carry;
        done_next   = 1'b1;
        result_next = make_rsp(op, top, ST_OK, count);
        state_next  = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
    idx    <= idx_next;
    carry  <= carry_next;
    top    <= top_next;
    op     <= op_next;
    result <= result_next;
  end

  assign busy = (state != S_IDLE);

endmodule
